### sv/thse_pkg.sv
// Shared constants and types of the tombstone hash set engine.
package thse_pkg;

   localparam int LINE_WORDS = 16;
   localparam int LINE_BITS  = $clog2(LINE_WORDS);
   localparam int LOG_LO     = LINE_BITS;
   localparam int MAX_REHASH = 1000;
   localparam int RH_BITS    = $clog2(MAX_REHASH + 1);
   localparam int ROT_LEFT   = 13;
   localparam int STEP_SHIFT = 4;

   localparam logic [31:0] HASH_EMPTY = 32'd0;
   localparam logic [31:0] HASH_TOMB  = 32'd1;

   localparam logic [1:0] ACT_LOOKUP = 2'd0;
   localparam logic [1:0] ACT_INSERT = 2'd1;
   localparam logic [1:0] ACT_DELETE = 2'd2;
   localparam logic [1:0] ACT_CLEAR  = 2'd3;

   localparam logic [1:0] STS_ABSENT  = 2'd0;
   localparam logic [1:0] STS_PRESENT = 2'd1;
   localparam logic [1:0] STS_FULL    = 2'd2;

   localparam logic CSR_INIT_LOG = 1'b0;
   localparam logic CSR_MAX_LOG  = 1'b1;

   typedef struct packed {
      logic       done;
      logic [1:0] code;
      logic       tomb_seen;
   } probe_res_type;

endpackage

### sv/thse_probe.sv
// Probe sequencer: walks lines and rehash rounds, one slot read per cycle.
module thse_probe import thse_pkg::*; #(
   parameter int ADDR_BITS = 10,
   parameter int KEY_BITS  = 32,
   parameter int LOG_BITS  = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [31:0]          hash,
   input  logic [KEY_BITS-1:0]  key,
   input  logic [LOG_BITS-1:0]  log_size,
   input  logic [31:0]          rd_hash,
   input  logic [KEY_BITS-1:0]  rd_key,
   output logic [ADDR_BITS-1:0] rd_addr,
   output logic [ADDR_BITS-1:0] hit_addr,
   output logic [ADDR_BITS-1:0] tomb_addr,
   output probe_res_type        res
);

   localparam logic [ADDR_BITS-1:0] LMASK = ADDR_BITS'(LINE_WORDS - 1);

   logic                  active_ff;
   logic                  issuing_ff;
   logic [31:0]           pos_ff;
   logic [RH_BITS-1:0]    rh_ff;
   logic [LINE_BITS-1:0]  idx_ff;
   logic [ADDR_BITS-1:0]  r_ff;
   logic                  pend_ff;
   logic [ADDR_BITS-1:0]  pend_addr_ff;
   logic                  pend_last_ff;
   logic                  tv_ff;
   logic [ADDR_BITS-1:0]  tomb_ff;

   logic [ADDR_BITS-1:0]  mask;
   logic [31:0]           step;
   logic [31:0]           home;
   logic [31:0]           pos_next;
   logic [ADDR_BITS-1:0]  r_nx;
   logic                  is_empty;
   logic                  is_tomb;
   logic                  is_match;
   logic                  done;

   always_comb begin
      for (int k = 0; k < ADDR_BITS; k++) begin
         mask[k] = (k < int'(log_size));
      end
   end

   assign step     = {17'b0, hash[9:0], 1'b1, 4'b0};
   assign home     = {hash[31-ROT_LEFT:0], hash[31:32-ROT_LEFT]};
   assign pos_next = pos_ff + step;
   assign r_nx     = (r_ff & ~LMASK) | ((r_ff + 1'b1) & LMASK);

   assign is_empty = (rd_hash == HASH_EMPTY);
   assign is_tomb  = (rd_hash == HASH_TOMB);
   assign is_match = (rd_hash == hash) && (rd_key == key);
   assign done     = active_ff & pend_ff & (is_empty | is_match | pend_last_ff);

   assign rd_addr   = r_ff;
   assign hit_addr  = pend_addr_ff;
   assign tomb_addr = tomb_ff;

   assign res.done      = done;
   assign res.code      = is_empty ? STS_ABSENT : (is_match ? STS_PRESENT : STS_FULL);
   assign res.tomb_seen = tv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         issuing_ff <= 1'b0;
         pend_ff    <= 1'b0;
         tv_ff      <= 1'b0;
      end else if (start) begin
         active_ff  <= 1'b1;
         issuing_ff <= 1'b1;
         pend_ff    <= 1'b0;
         tv_ff      <= 1'b0;
         pos_ff     <= home;
         rh_ff      <= '0;
         idx_ff     <= '0;
         r_ff       <= home[ADDR_BITS-1:0] & mask;
      end else if (active_ff) begin
         if (done) begin
            active_ff  <= 1'b0;
            issuing_ff <= 1'b0;
            pend_ff    <= 1'b0;
         end else begin
            pend_ff      <= issuing_ff;
            pend_addr_ff <= r_ff;
            pend_last_ff <= issuing_ff && (idx_ff == LINE_BITS'(LINE_WORDS - 1))
                            && (rh_ff == RH_BITS'(MAX_REHASH));
            if (issuing_ff) begin
               if (idx_ff == LINE_BITS'(LINE_WORDS - 1)) begin
                  idx_ff <= '0;
                  pos_ff <= pos_next;
                  r_ff   <= pos_next[ADDR_BITS-1:0] & mask;
                  if (rh_ff == RH_BITS'(MAX_REHASH)) begin
                     issuing_ff <= 1'b0;
                  end else begin
                     rh_ff <= rh_ff + 1'b1;
                  end
               end else begin
                  idx_ff <= idx_ff + 1'b1;
                  r_ff   <= r_nx;
               end
            end
            // first tombstone on the path is kept for reuse
            if (pend_ff && is_tomb && !tv_ff) begin
               tv_ff   <= 1'b1;
               tomb_ff <= pend_addr_ff;
            end
         end
      end
   end

endmodule

### sv/tombstone_hash_set_engine.sv
// Top level of the tombstone hash set engine: control FSM, slot and scratch memories.
//
// Usage:
//  - Request beats (req_*) carry action, key, key hash and data; a beat is taken
//    when req_valid is high and req_stall low. req_stall is high whenever an
//    operation is in progress; one operation is in flight at a time.
//  - Every request yields exactly one response beat (rsp_*): status, data and the
//    live entry count after the operation, rebuild included.
//  - A finished response waits in the output register while rsp_stall is high;
//    the next request is taken meanwhile, and its result waits until that
//    register is free.
//  - Lookup reads the probed slots one by one; insert then writes the chosen slot;
//    delete then reads the next slot and, if it is empty, wipes back, reading
//    each trailing tombstone and the slot that stops the walk. Clear writes every
//    slot of the current table. A rebuild sweeps the old table into scratch, then
//    reinserts each live entry with a new probe. Sustained rate is set by the single
//    read port of the slot memory.
//  - Reset: a clearing pass writes every slot empty, one per cycle; requests are
//    stalled until it ends. CSR writes (csr_valid with csr_ready, always high) are
//    taken at any time; the initial log size applies at the next clear (reset
//    restores the defaults), and both log sizes move the grow/shrink bounds at once.
module tombstone_hash_set_engine import thse_pkg::*; #(
   parameter int TABLE_DEPTH = 1024,
   parameter int KEY_BITS    = 32,
   parameter int DATA_BITS   = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_action,
   input  logic [KEY_BITS-1:0]                 req_key,
   input  logic [31:0]                         req_key_hash,
   input  logic [DATA_BITS-1:0]                req_data_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic [DATA_BITS-1:0]                rsp_data_out,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]    rsp_live_count,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_index,
   input  logic [3:0]                          csr_wdata
);

   localparam int AW     = $clog2(TABLE_DEPTH);
   localparam int CW     = $clog2(TABLE_DEPTH + 1);
   localparam int LOG_HI = $clog2(TABLE_DEPTH + 1) - 1;
   localparam int LW     = $clog2(LOG_HI + 1);
   localparam int WW     = 32 + KEY_BITS + DATA_BITS;
   localparam int XW     = AW + 4;
   localparam logic [AW-1:0] LMASK = AW'(LINE_WORDS - 1);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_PROBE, ST_INS, ST_DEL_RD_NEXT, ST_DEL_CHK_NEXT,
      ST_DEL_RD_BACK, ST_DEL_CHK_BACK, ST_POST, ST_SWEEP, ST_LOAD, ST_LOAD_WAIT,
      ST_RESP
   } state_type;

   function automatic logic [LW-1:0] clamp_log(input logic [3:0] v);
      logic [7:0] w;
      w = {4'b0, v};
      if (w < 8'(LOG_LO)) w = 8'(LOG_LO);
      if (w > 8'(LOG_HI)) w = 8'(LOG_HI);
      return LW'(w);
   endfunction

   function automatic logic [AW-1:0] line_next(input logic [AW-1:0] a);
      return (a & ~LMASK) | ((a + 1'b1) & LMASK);
   endfunction

   function automatic logic [AW-1:0] line_prev(input logic [AW-1:0] a);
      return (a & ~LMASK) | ((a - 1'b1) & LMASK);
   endfunction

   // slot word: {hash, key, data}
   logic [WW-1:0] slot_mem [TABLE_DEPTH];
   logic [WW-1:0] scr_mem  [TABLE_DEPTH];
   logic [WW-1:0] mem_rd_ff;
   logic [WW-1:0] scr_rd_ff;

   state_type            state_ff;
   logic [3:0]           init_ff;
   logic [3:0]           max_ff;
   logic [LW-1:0]        cur_log_ff;
   logic [LW-1:0]        new_log_ff;
   logic [CW-1:0]        live_ff;
   logic [CW-1:0]        tomb_ff;
   logic [1:0]           act_ff;
   logic [31:0]          h_ff;
   logic [KEY_BITS-1:0]  key_ff;
   logic [DATA_BITS-1:0] data_ff;
   logic [1:0]           st_ff;
   logic [DATA_BITS-1:0] dout_ff;
   logic [AW-1:0]        ref_ff;
   logic [AW-1:0]        cur_ff;
   logic                 tv_ff;
   logic                 reb_ff;
   logic                 start_ff;
   logic [AW:0]          clr_idx_ff;
   logic [AW:0]          clr_lim_ff;
   logic                 clr_req_ff;
   logic [AW:0]          sw_idx_ff;
   logic                 sw_pend_ff;
   logic [AW-1:0]        sw_addr_ff;
   logic [AW:0]          scr_n_ff;
   logic [AW:0]          scr_j_ff;
   logic                 rsp_valid_ff;
   logic [1:0]           rsp_status_ff;
   logic [DATA_BITS-1:0] rsp_data_ff;
   logic [CW-1:0]        rsp_live_ff;

   logic [AW-1:0]        probe_addr;
   logic [AW-1:0]        hit_addr;
   logic [AW-1:0]        tomb_addr;
   probe_res_type        pres;

   logic [31:0]          rd_hash;
   logic [KEY_BITS-1:0]  rd_key;
   logic [DATA_BITS-1:0] rd_data;
   logic [AW-1:0]        rd_addr;
   logic                 slot_we;
   logic [AW-1:0]        slot_wa;
   logic [WW-1:0]        slot_wd;
   logic                 scr_we;

   logic [LW-1:0]        eff_init;
   logic [LW-1:0]        eff_max;
   logic [LW-1:0]        max_clamped;
   logic [AW:0]          size;
   logic [XW-1:0]        size_x;
   logic [XW-1:0]        live_x;
   logic [XW-1:0]        tomb_x;
   logic                 tomb_over;
   logic                 shrink;
   logic                 grow;

   assign rd_hash = mem_rd_ff[WW-1 -: 32];
   assign rd_key  = mem_rd_ff[DATA_BITS +: KEY_BITS];
   assign rd_data = mem_rd_ff[DATA_BITS-1:0];

   assign eff_init    = clamp_log(init_ff);
   assign max_clamped = clamp_log(max_ff);
   assign eff_max     = (max_clamped < eff_init) ? eff_init : max_clamped;

   assign size   = (AW+1)'(1) << cur_log_ff;
   assign size_x = XW'(size);
   assign live_x = XW'(live_ff);
   assign tomb_x = XW'(tomb_ff);

   // rebuild triggers, evaluated once the counts are final
   assign tomb_over = (tomb_x << 1) > size_x;
   assign shrink    = (cur_log_ff > eff_init) && (live_x < (size_x >> 3));
   assign grow      = (((live_x + tomb_x) << 2) > ((size_x << 1) + size_x))
                      && (cur_log_ff < eff_max);

   thse_probe #(
      .ADDR_BITS (AW),
      .KEY_BITS  (KEY_BITS),
      .LOG_BITS  (LW)
   ) u_probe (
      .clock     (clock),
      .reset     (reset),
      .start     (start_ff),
      .hash      (h_ff),
      .key       (key_ff),
      .log_size  (cur_log_ff),
      .rd_hash   (rd_hash),
      .rd_key    (rd_key),
      .rd_addr   (probe_addr),
      .hit_addr  (hit_addr),
      .tomb_addr (tomb_addr),
      .res       (pres)
   );

   // slot memory read address
   always_comb begin
      unique case (state_ff)
         ST_DEL_RD_NEXT: rd_addr = line_next(ref_ff);
         ST_DEL_RD_BACK: rd_addr = cur_ff;
         ST_SWEEP:       rd_addr = sw_idx_ff[AW-1:0];
         default:        rd_addr = probe_addr;
      endcase
   end

   // slot memory write port
   always_comb begin
      slot_we = 1'b0;
      slot_wa = ref_ff;
      slot_wd = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            slot_we = 1'b1;
            slot_wa = clr_idx_ff[AW-1:0];
         end
         ST_PROBE: begin
            slot_we = pres.done && reb_ff && (pres.code == STS_ABSENT);
            slot_wa = hit_addr;
            slot_wd = {h_ff, key_ff, data_ff};
         end
         ST_INS: begin
            slot_we = 1'b1;
            slot_wd = {h_ff, key_ff, data_ff};
         end
         ST_DEL_CHK_NEXT: begin
            slot_we = 1'b1;
            slot_wd = {((rd_hash != HASH_EMPTY) ? HASH_TOMB : HASH_EMPTY),
                       {(KEY_BITS + DATA_BITS){1'b0}}};
         end
         ST_DEL_CHK_BACK: begin
            slot_we = (rd_hash == HASH_TOMB);
            slot_wa = cur_ff;
         end
         ST_SWEEP: begin
            slot_we = sw_pend_ff;
            slot_wa = sw_addr_ff;
         end
         default: ;
      endcase
   end

   assign scr_we = (state_ff == ST_SWEEP) && sw_pend_ff && (rd_hash > HASH_TOMB);

   always_ff @(posedge clock) begin
      mem_rd_ff <= slot_mem[rd_addr];
      if (slot_we) begin
         slot_mem[slot_wa] <= slot_wd;
      end
   end

   always_ff @(posedge clock) begin
      scr_rd_ff <= scr_mem[scr_j_ff[AW-1:0]];
      if (scr_we) begin
         scr_mem[scr_n_ff[AW-1:0]] <= mem_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         init_ff      <= 4'd4;
         max_ff       <= 4'd10;
         cur_log_ff   <= clamp_log(4'd4);
         live_ff      <= '0;
         tomb_ff      <= '0;
         clr_idx_ff   <= '0;
         clr_lim_ff   <= (AW+1)'(TABLE_DEPTH);
         clr_req_ff   <= 1'b0;
         start_ff     <= 1'b0;
         sw_pend_ff   <= 1'b0;
         reb_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_INIT_LOG: init_ff <= csr_wdata;
               CSR_MAX_LOG:  max_ff  <= csr_wdata;
               default: ;
            endcase
         end
         // the response state refills the output register itself
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_RESP) begin
            rsp_valid_ff <= 1'b0;
         end
         start_ff <= 1'b0;

         unique case (state_ff)
            ST_CLEAR: begin
               clr_idx_ff <= clr_idx_ff + 1'b1;
               if (clr_idx_ff + 1'b1 == clr_lim_ff) begin
                  live_ff    <= '0;
                  tomb_ff    <= '0;
                  if (clr_req_ff) begin
                     cur_log_ff <= eff_init;
                     st_ff      <= STS_ABSENT;
                     dout_ff    <= '0;
                     state_ff   <= ST_RESP;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  act_ff  <= req_action;
                  key_ff  <= req_key;
                  data_ff <= req_data_in;
                  // hashes 0 and 1 are reserved markers
                  h_ff    <= req_key_hash | {30'b0, (req_key_hash[31:1] == 31'b0), 1'b0};
                  if (req_action == ACT_CLEAR) begin
                     clr_idx_ff <= '0;
                     clr_lim_ff <= size;
                     clr_req_ff <= 1'b1;
                     state_ff   <= ST_CLEAR;
                  end else begin
                     reb_ff   <= 1'b0;
                     start_ff <= 1'b1;
                     state_ff <= ST_PROBE;
                  end
               end
            end
            ST_PROBE: begin
               if (pres.done) begin
                  if (reb_ff) begin
                     if (pres.code == STS_ABSENT) begin
                        live_ff <= live_ff + 1'b1;
                     end
                     scr_j_ff <= scr_j_ff + 1'b1;
                     state_ff <= (scr_j_ff + 1'b1 == scr_n_ff) ? ST_RESP : ST_LOAD;
                  end else begin
                     st_ff <= pres.code;
                     if (pres.code == STS_PRESENT) begin
                        dout_ff <= rd_data;
                        if (act_ff == ACT_DELETE) begin
                           ref_ff   <= hit_addr;
                           live_ff  <= (live_ff != '0) ? live_ff - 1'b1 : live_ff;
                           state_ff <= ST_DEL_RD_NEXT;
                        end else begin
                           state_ff <= ST_RESP;
                        end
                     end else if (pres.code == STS_ABSENT && act_ff == ACT_INSERT) begin
                        ref_ff   <= pres.tomb_seen ? tomb_addr : hit_addr;
                        tv_ff    <= pres.tomb_seen;
                        dout_ff  <= data_ff;
                        state_ff <= ST_INS;
                     end else begin
                        dout_ff  <= '0;
                        state_ff <= ST_RESP;
                     end
                  end
               end
            end
            ST_INS: begin
               live_ff <= live_ff + 1'b1;
               if (tv_ff && tomb_ff != '0) begin
                  tomb_ff <= tomb_ff - 1'b1;
               end
               state_ff <= ST_POST;
            end
            ST_DEL_RD_NEXT: begin
               state_ff <= ST_DEL_CHK_NEXT;
            end
            ST_DEL_CHK_NEXT: begin
               // next slot occupied: leave a tombstone; else wipe back
               if (rd_hash != HASH_EMPTY) begin
                  tomb_ff  <= tomb_ff + 1'b1;
                  state_ff <= ST_POST;
               end else begin
                  cur_ff   <= line_prev(ref_ff);
                  state_ff <= ST_DEL_RD_BACK;
               end
            end
            ST_DEL_RD_BACK: begin
               state_ff <= ST_DEL_CHK_BACK;
            end
            ST_DEL_CHK_BACK: begin
               if (rd_hash == HASH_TOMB) begin
                  tomb_ff  <= (tomb_ff != '0) ? tomb_ff - 1'b1 : tomb_ff;
                  cur_ff   <= line_prev(cur_ff);
                  state_ff <= ST_DEL_RD_BACK;
               end else begin
                  state_ff <= ST_POST;
               end
            end
            ST_POST: begin
               sw_idx_ff  <= '0;
               sw_pend_ff <= 1'b0;
               scr_n_ff   <= '0;
               state_ff   <= ST_SWEEP;
               if (act_ff == ACT_DELETE) begin
                  if (shrink) begin
                     new_log_ff <= cur_log_ff - 1'b1;
                  end else if (tomb_over) begin
                     new_log_ff <= cur_log_ff;
                  end else begin
                     state_ff <= ST_RESP;
                  end
               end else begin
                  if (tomb_over) begin
                     new_log_ff <= cur_log_ff;
                  end else if (grow) begin
                     new_log_ff <= cur_log_ff + 1'b1;
                  end else begin
                     state_ff <= ST_RESP;
                  end
               end
            end
            ST_SWEEP: begin
               // gather live words into scratch, emptying the old table
               if (sw_idx_ff < size) begin
                  sw_idx_ff  <= sw_idx_ff + 1'b1;
                  sw_pend_ff <= 1'b1;
                  sw_addr_ff <= sw_idx_ff[AW-1:0];
               end else begin
                  sw_pend_ff <= 1'b0;
               end
               if (scr_we) begin
                  scr_n_ff <= scr_n_ff + 1'b1;
               end
               if (sw_idx_ff == size && !sw_pend_ff) begin
                  cur_log_ff <= new_log_ff;
                  tomb_ff    <= '0;
                  live_ff    <= '0;
                  scr_j_ff   <= '0;
                  state_ff   <= (scr_n_ff == '0) ? ST_RESP : ST_LOAD;
               end
            end
            ST_LOAD: begin
               state_ff <= ST_LOAD_WAIT;
            end
            ST_LOAD_WAIT: begin
               h_ff     <= scr_rd_ff[WW-1 -: 32];
               key_ff   <= scr_rd_ff[DATA_BITS +: KEY_BITS];
               data_ff  <= scr_rd_ff[DATA_BITS-1:0];
               reb_ff   <= 1'b1;
               start_ff <= 1'b1;
               state_ff <= ST_PROBE;
            end
            ST_RESP: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= st_ff;
                  rsp_data_ff   <= dout_ff;
                  rsp_live_ff   <= live_ff;
                  clr_req_ff    <= 1'b0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_data_out   = rsp_data_ff;
   assign rsp_live_count = rsp_live_ff;

`ifndef ASSERT_OFF
   a_counts_fit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ((live_x + tomb_x) <= size_x))
      else $error("live plus tombstone count exceeds table size");

   a_probe_done_in_probe: assert property (@(posedge clock) disable iff (reset)
      pres.done |-> (state_ff == ST_PROBE))
      else $error("probe finished outside probe state");

   a_log_in_range: assert property (@(posedge clock) disable iff (reset)
      (cur_log_ff >= LW'(LOG_LO)) && (cur_log_ff <= LW'(LOG_HI)))
      else $error("table log size out of range");
`endif

endmodule
